FILE: rtl/coarse_tile_binner_unit_macros.svh
// Assertion macros for the coarse tile binner.
`ifndef COARSE_TILE_BINNER_UNIT_MACROS_SVH
`define COARSE_TILE_BINNER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CTB_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define CTB_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define CTB_ASSERT_IMP(label, clk, rst, pre, post)
`define CTB_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/ctb_pkg.sv
// Shared types and constants for the coarse tile binner.
package ctb_pkg;
  localparam int TileUnits = 32 * 16;
  localparam int TileShift = 9;
  localparam int SlabCap = 8192;
  localparam int QuadsPerSlab = 16;
  localparam int FineRatioSq = 16;
  localparam int MaxSide = 64;
  localparam int TileCount = MaxSide * MaxSide + 1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [0:0] REG_TILES_X = 1'b0;
  localparam logic [0:0] REG_TILES_Y = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic [15:0] quad_id;
    logic [12:0] slab_index;
    logic [3:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [12:0] tile_index;
    logic [31:0] fine_offset;
    logic [15:0] depth;
    logic [15:0] entry_quad;
    logic [12:0] next_slab;
    logic overflow;
    logic last;
  } result_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] sx;
    logic [6:0] sy;
    logic [6:0] ex;
    logic [6:0] ey;
    logic [15:0] quad_id;
    logic [12:0] slab_index;
    logic [3:0] slot_index;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WAIT, ST_ADD_WR, ST_ADD_NEXT,
    ST_REP_RD, ST_REP_WAIT, ST_REP_WALK, ST_REP_OUT, ST_READ_RD, ST_READ_WAIT,
    ST_READ_OUT, ST_DONE
  } state_t;

  // floor of a 12.4 coordinate to tiles, clamped to 0..side
  function automatic logic [6:0] floor_clamp(logic signed [15:0] v, logic [6:0] side);
    logic signed [6:0] t;
    t = 7'(v >>> TileShift);
    if (t < 0) return 7'd0;
    if ($unsigned(t) > side) return side;
    return $unsigned(t);
  endfunction

  function automatic logic [6:0] ceil_clamp(logic signed [15:0] v, logic [6:0] side);
    logic signed [17:0] w;
    logic signed [8:0] t;
    w = 18'(v) + 18'(TileUnits - 1);
    t = 9'(w >>> TileShift);
    if (t < 0) return 7'd0;
    if (t > $signed({2'b0, side})) return side;
    return t[6:0];
  endfunction
endpackage

FILE: rtl/ctb_front.sv
// Front end: takes requests, computes clamped tile ranges, feeds a two-entry queue.
`include "coarse_tile_binner_unit_macros.svh"
module ctb_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  ctb_pkg::req_t req,
  input  logic [6:0] side_x,
  input  logic [6:0] side_y,
  output logic q_full,
  output logic q_valid,
  output ctb_pkg::cmd_t q_cmd,
  input  logic q_pop
);
  ctb_pkg::cmd_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  ctb_pkg::cmd_t cmd;

  always_comb begin
    cmd.kind = req.kind;
    cmd.sx = ctb_pkg::floor_clamp(req.min_x, side_x);
    cmd.sy = ctb_pkg::floor_clamp(req.min_y, side_y);
    cmd.ex = ctb_pkg::ceil_clamp(req.max_x, side_x);
    cmd.ey = ctb_pkg::ceil_clamp(req.max_y, side_y);
    cmd.quad_id = req.quad_id;
    cmd.slab_index = req.slab_index;
    cmd.slot_index = req.slot_index;
  end

  assign q_full = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid) mem[wp] <= cmd;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(in_valid) - 2'(q_pop);
    end
  end

  `CTB_ASSERT_IMP(a_no_push_full, clk, rst, q_full, !in_valid)
  `CTB_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, q_valid)
  `CTB_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count != 2'd3)
endmodule

FILE: rtl/ctb_back.sv
// Back end: tile tables, slab memories, report walk and result register.
`include "coarse_tile_binner_unit_macros.svh"
module ctb_back (
  input  logic clk,
  input  logic rst,
  input  logic reinit,
  input  logic [6:0] side_x,
  input  logic [6:0] side_y,
  input  logic q_valid,
  input  ctb_pkg::cmd_t q_cmd,
  output logic q_pop,
  output logic idle,
  output logic result_strobe,
  output ctb_pkg::result_t result
);
  logic [15:0] entries [ctb_pkg::SlabCap * ctb_pkg::QuadsPerSlab];
  logic [12:0] links [ctb_pkg::SlabCap];
  logic [12:0] heads [ctb_pkg::TileCount];
  logic [4:0] fills [ctb_pkg::TileCount];

  ctb_pkg::state_t state, state_next;
  ctb_pkg::cmd_t cmd;
  logic [12:0] clr;
  logic [13:0] alloc_pointer;
  logic [12:0] report_cursor;
  logic [31:0] offset_accumulator;
  logic overflow_flag;
  logic [6:0] cx, cy;
  logic [12:0] tile;
  logic [12:0] rowbase;
  logic [12:0] head_q, link_q;
  logic [4:0] fill_q;
  logic [15:0] entry_q;
  logic [12:0] walk;
  logic [16:0] depth_acc;
  logic [12:0] total;
  logic [12:0] link_addr;
  logic [31:0] acc_sum;
  logic [12:0] cur_eff;
  logic [15:0] dsat;
  logic head_ok;

  assign total = 13'(side_x) * 13'(side_y);
  assign q_pop = (state == ctb_pkg::ST_IDLE) && q_valid;
  assign idle = (state == ctb_pkg::ST_IDLE) && !q_valid;
  assign head_ok = {1'b0, head_q} < 14'(ctb_pkg::SlabCap);

  always_comb begin
    state_next = state;
    case (state)
      ctb_pkg::ST_CLEAR: if (clr == 13'(ctb_pkg::SlabCap - 1)) state_next = ctb_pkg::ST_IDLE;
      ctb_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            ctb_pkg::KIND_ADD: state_next = ctb_pkg::ST_ADD_NEXT;
            ctb_pkg::KIND_REPORT: state_next = ctb_pkg::ST_REP_RD;
            ctb_pkg::KIND_READ: state_next = ctb_pkg::ST_READ_RD;
            default: state_next = ctb_pkg::ST_CLEAR;
          endcase
        end
      end
      ctb_pkg::ST_ADD_NEXT:
        state_next = (cy < cmd.ey && cmd.sx < cmd.ex) ? ctb_pkg::ST_ADD_RD : ctb_pkg::ST_DONE;
      ctb_pkg::ST_ADD_RD: state_next = ctb_pkg::ST_ADD_WAIT;
      ctb_pkg::ST_ADD_WAIT: state_next = ctb_pkg::ST_ADD_WR;
      ctb_pkg::ST_ADD_WR: state_next = ctb_pkg::ST_ADD_NEXT;
      ctb_pkg::ST_REP_RD: state_next = ctb_pkg::ST_REP_WAIT;
      ctb_pkg::ST_REP_WAIT: state_next = ctb_pkg::ST_REP_WALK;
      ctb_pkg::ST_REP_WALK:
        if (link_q == 13'd0 || depth_acc >= 17'd65535) state_next = ctb_pkg::ST_REP_OUT;
      ctb_pkg::ST_REP_OUT: state_next = ctb_pkg::ST_IDLE;
      ctb_pkg::ST_READ_RD: state_next = ctb_pkg::ST_READ_WAIT;
      ctb_pkg::ST_READ_WAIT: state_next = ctb_pkg::ST_READ_OUT;
      ctb_pkg::ST_READ_OUT: state_next = ctb_pkg::ST_IDLE;
      ctb_pkg::ST_DONE: state_next = ctb_pkg::ST_IDLE;
      default: state_next = ctb_pkg::ST_IDLE;
    endcase
    if (reinit) state_next = ctb_pkg::ST_CLEAR;
  end

  assign tile = rowbase + 13'(cx) + 13'd1;

  // memories: one address per cycle each
  always_comb begin
    case (state)
      ctb_pkg::ST_REP_WALK: link_addr = link_q;
      ctb_pkg::ST_REP_RD: link_addr = cur_eff;
      ctb_pkg::ST_REP_WAIT: link_addr = report_cursor;
      default: link_addr = cmd.slab_index;
    endcase
  end

  always_ff @(posedge clk) begin
    head_q <= heads[tile];
    fill_q <= fills[tile];
    entry_q <= entries[{cmd.slab_index, cmd.slot_index}];
    link_q <= links[link_addr];
    if (state == ctb_pkg::ST_CLEAR) begin
      links[clr] <= 13'd0;
      if (clr < 13'(ctb_pkg::TileCount)) begin
        heads[clr] <= clr;
        fills[clr] <= 5'd0;
      end
    end
    if (state == ctb_pkg::ST_ADD_WR && head_ok) begin
      if (fill_q >= 5'(ctb_pkg::QuadsPerSlab)) begin
        if (alloc_pointer < 14'(ctb_pkg::SlabCap)) begin
          links[head_q] <= alloc_pointer[12:0];
          heads[tile] <= alloc_pointer[12:0];
          fills[tile] <= 5'd1;
          entries[{alloc_pointer[12:0], 4'd0}] <= cmd.quad_id;
        end
      end else begin
        entries[{head_q, fill_q[3:0]}] <= cmd.quad_id;
        fills[tile] <= fill_q + 5'd1;
      end
    end
  end

  always_comb begin
    cur_eff = (report_cursor == 13'd0 || report_cursor > total) ? 13'd1 : report_cursor;
    dsat = depth_acc > 17'd65535 ? 16'hFFFF : depth_acc[15:0];
    acc_sum = (33'(offset_accumulator) + {13'd0, dsat, 4'd0} > 33'hFFFFFFFF)
      ? 32'hFFFFFFFF : offset_accumulator + {12'd0, dsat, 4'd0};
  end

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst || reinit) cmd.kind <= ctb_pkg::KIND_ADD;
    else if (state == ctb_pkg::ST_IDLE && q_valid) begin
      cmd <= q_cmd;
      cx <= q_cmd.sx;
      cy <= q_cmd.sy;
      rowbase <= 13'(q_cmd.sy) * 13'(side_x);
    end
    if (state == ctb_pkg::ST_ADD_WR) begin
      if (cx + 7'd1 >= cmd.ex) begin
        cx <= cmd.sx;
        cy <= cy + 7'd1;
        rowbase <= rowbase + 13'(side_x);
      end else cx <= cx + 7'd1;
    end
    if (state == ctb_pkg::ST_REP_WAIT) depth_acc <= 17'(fills[report_cursor]);
    if (state == ctb_pkg::ST_REP_WALK && link_q != 13'd0 && depth_acc < 17'd65535)
      depth_acc <= depth_acc + 17'(ctb_pkg::QuadsPerSlab);
    result <= '0;
    if (state == ctb_pkg::ST_REP_OUT) begin
      result_strobe <= 1'b1;
      result.tile_index <= report_cursor;
      result.fine_offset <= offset_accumulator;
      result.depth <= dsat;
      result.last <= report_cursor == total;
      result.overflow <= overflow_flag;
    end
    if (state == ctb_pkg::ST_READ_OUT) begin
      result_strobe <= 1'b1;
      result.entry_quad <= entry_q;
      result.next_slab <= link_q;
      result.overflow <= overflow_flag;
    end
    if (state == ctb_pkg::ST_DONE || (state == ctb_pkg::ST_CLEAR &&
        clr == 13'(ctb_pkg::SlabCap - 1) && cmd.kind == ctb_pkg::KIND_CLEAR)) begin
      result_strobe <= 1'b1;
      result.overflow <= (state == ctb_pkg::ST_CLEAR) ? 1'b0 : overflow_flag;
    end
    if (rst) result_strobe <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctb_pkg::ST_CLEAR;
      clr <= 13'd0;
    end else begin
      state <= state_next;
      clr <= (state == ctb_pkg::ST_CLEAR && !reinit) ? clr + 13'd1 : 13'd0;
    end
    if (rst || reinit || state == ctb_pkg::ST_CLEAR) begin
      alloc_pointer <= 14'(total) + 14'd1;
      report_cursor <= 13'd1;
      offset_accumulator <= 32'd0;
      overflow_flag <= 1'b0;
    end else begin
      if (state == ctb_pkg::ST_ADD_WR) begin
        if (!head_ok) overflow_flag <= 1'b1;
        else if (fill_q >= 5'(ctb_pkg::QuadsPerSlab)) begin
          if (alloc_pointer < 14'(ctb_pkg::SlabCap)) alloc_pointer <= alloc_pointer + 14'd1;
          else overflow_flag <= 1'b1;
        end
      end
      if (state == ctb_pkg::ST_REP_RD && cur_eff != report_cursor) begin
        report_cursor <= cur_eff;
        offset_accumulator <= 32'd0;
      end
      if (state == ctb_pkg::ST_REP_OUT) begin
        if (report_cursor == total) begin
          report_cursor <= 13'd1;
          offset_accumulator <= 32'd0;
        end else begin
          report_cursor <= report_cursor + 13'd1;
          offset_accumulator <= acc_sum;
        end
      end
    end
  end

  `CTB_ASSERT_NXT(a_one_strobe, clk, rst, result_strobe, !result_strobe)
  `CTB_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == ctb_pkg::ST_IDLE)
  `CTB_ASSERT_IMP(a_alloc_cap, clk, rst, 1'b1, alloc_pointer <= 14'(ctb_pkg::SlabCap) + 14'd1 || state == ctb_pkg::ST_CLEAR)
endmodule

FILE: rtl/coarse_tile_binner_unit.sv
// Top level: coarse tile binner with decoupled front and back ends.
// A report's strobe comes later for each slab link walked, and an add's for each covered tile;
// a queued request also waits for the one ahead of it.
// Throughput: one request at a time in the back end; the front queue holds two, busy when full.
// Reset and each register write run a clear pass over all slabs; cfg_ready is low until idle.
// Exactly one result strobe per request; the receiver cannot stall.
`include "coarse_tile_binner_unit_macros.svh"
module coarse_tile_binner_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ctb_pkg::req_t req,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic result_strobe,
  output ctb_pkg::result_t result
);
  logic [6:0] tiles_x, tiles_y, side_x, side_y;
  logic q_full, q_valid, q_pop, idle, cfg_fire;
  ctb_pkg::cmd_t q_cmd;

  assign cfg_ready = idle;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign busy = q_full;
  assign side_x = tiles_x == 7'd0 ? 7'd1 :
    (tiles_x > 7'(ctb_pkg::MaxSide) ? 7'(ctb_pkg::MaxSide) : tiles_x);
  assign side_y = tiles_y == 7'd0 ? 7'd1 :
    (tiles_y > 7'(ctb_pkg::MaxSide) ? 7'(ctb_pkg::MaxSide) : tiles_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_x <= 7'(ctb_pkg::MaxSide);
      tiles_y <= 7'(ctb_pkg::MaxSide);
    end else if (cfg_fire) begin
      case (cfg_index)
        ctb_pkg::REG_TILES_X: tiles_x <= cfg_data;
        ctb_pkg::REG_TILES_Y: tiles_y <= cfg_data;
        default: tiles_x <= tiles_x;
      endcase
    end
  end

  ctb_front u_front (
    .clk, .rst, .in_valid(start && !busy), .req, .side_x, .side_y,
    .q_full, .q_valid, .q_cmd, .q_pop
  );

  ctb_back u_back (
    .clk, .rst, .reinit(cfg_fire), .side_x, .side_y, .q_valid, .q_cmd, .q_pop,
    .idle, .result_strobe, .result
  );

  `CTB_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_fire, idle)
endmodule

FILE: test/tb_coarse_tile_binner_unit.sv
// Testbench for coarse_tile_binner_unit: directed and random requests against a scoreboard.
`timescale 1ns / 100ps

class binner_scoreboard;
  logic [15:0] entries[ctb_pkg::SlabCap*ctb_pkg::QuadsPerSlab];
  bit          filled[ctb_pkg::SlabCap*ctb_pkg::QuadsPerSlab];
  int          filled_list[$];
  logic [12:0] links[ctb_pkg::SlabCap];
  int          head[ctb_pkg::TileCount];
  int          fill[ctb_pkg::TileCount];
  int          alloc_ptr, cursor;
  logic [31:0] offset_acc;
  bit          ovf;
  logic [6:0]  grid_x = 7'd64, grid_y = 7'd64;
  ctb_pkg::result_t pending[$];
  int          errors;

  function int side(logic [6:0] v);
    if (v < 1) return 1;
    if (v > ctb_pkg::MaxSide) return ctb_pkg::MaxSide;
    return int'(v);
  endfunction

  function void wipe();
    foreach (links[i]) links[i] = '0;
    foreach (fill[i]) fill[i] = 0;
    foreach (head[i]) head[i] = i;
    foreach (filled[i]) filled[i] = 0;
    filled_list.delete();
    alloc_ptr = side(grid_x) * side(grid_y) + 1;
    cursor = 1;
    offset_acc = '0;
    ovf = 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [6:0] val);
    if (idx == ctb_pkg::REG_TILES_X) grid_x = val;
    else grid_y = val;
    wipe();
  endfunction

  function int floor_tile(int v);
    if (v >= 0) return v / ctb_pkg::TileUnits;
    return -((-v + ctb_pkg::TileUnits - 1) / ctb_pkg::TileUnits);
  endfunction

  function int ceil_tile(int v);
    if (v >= 0) return (v + ctb_pkg::TileUnits - 1) / ctb_pkg::TileUnits;
    return -((-v) / ctb_pkg::TileUnits);
  endfunction

  function void bin_quad(int t, logic [15:0] id);
    int h, a;
    h = head[t];
    if (h >= ctb_pkg::SlabCap) begin
      ovf = 1;
      return;
    end
    if (fill[t] >= ctb_pkg::QuadsPerSlab) begin
      if (alloc_ptr >= ctb_pkg::SlabCap) begin
        ovf = 1;
        return;
      end
      links[h] = alloc_ptr[12:0];
      h = alloc_ptr;
      alloc_ptr++;
      head[t] = h;
      fill[t] = 0;
    end
    a = h * ctb_pkg::QuadsPerSlab + fill[t];
    entries[a] = id;
    if (!filled[a]) begin
      filled[a] = 1;
      filled_list.push_back(a);
    end
    fill[t]++;
  endfunction

  function int tile_depth(int t);
    int d, s;
    d = fill[t];
    s = t;
    forever begin
      s = links[s];
      if (s == 0) break;
      d += ctb_pkg::QuadsPerSlab;
    end
    return d > 65535 ? 65535 : d;
  endfunction

  // predict the result of an accepted request
  function void note(ctb_pkg::req_t r);
    ctb_pkg::result_t res;
    int tx, ty, total, sx, sy, ex, ey, d;
    logic [32:0] acc;
    tx = side(grid_x);
    ty = side(grid_y);
    total = tx * ty;
    res = '0;
    case (r.kind)
      ctb_pkg::KIND_ADD: begin
        sx = floor_tile(int'(r.min_x));
        sy = floor_tile(int'(r.min_y));
        ex = ceil_tile(int'(r.max_x));
        ey = ceil_tile(int'(r.max_y));
        if (sx < 0) sx = 0;
        if (sy < 0) sy = 0;
        if (ex > tx) ex = tx;
        if (ey > ty) ey = ty;
        for (int y = sy; y < ey; y++)
          for (int x = sx; x < ex; x++) bin_quad(y * tx + x + 1, r.quad_id);
      end
      ctb_pkg::KIND_REPORT: begin
        if (cursor < 1 || cursor > total) begin
          cursor = 1;
          offset_acc = '0;
        end
        d = tile_depth(cursor);
        res.tile_index = cursor[12:0];
        res.fine_offset = offset_acc;
        res.depth = d[15:0];
        acc = {1'b0, offset_acc} + 33'(ctb_pkg::FineRatioSq * d);
        offset_acc = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        if (cursor == total) begin
          res.last = 1'b1;
          cursor = 1;
          offset_acc = '0;
        end else begin
          cursor++;
        end
      end
      ctb_pkg::KIND_READ: begin
        res.entry_quad = entries[r.slab_index * ctb_pkg::QuadsPerSlab + r.slot_index];
        res.next_slab = links[r.slab_index];
      end
      default: wipe();
    endcase
    res.overflow = ovf;
    pending.push_back(res);
  endfunction

  function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check(ctb_pkg::result_t got);
    ctb_pkg::result_t want;
    if (pending.size() == 0) begin
      $error("result strobe with no request outstanding");
      errors++;
      return;
    end
    want = pending.pop_front();
    field("tile_index", want.tile_index, got.tile_index);
    field("fine_offset", want.fine_offset, got.fine_offset);
    field("depth", want.depth, got.depth);
    field("entry_quad", want.entry_quad, got.entry_quad);
    field("next_slab", want.next_slab, got.next_slab);
    field("overflow", want.overflow, got.overflow);
    field("last", want.last, got.last);
  endfunction
endclass

module tb_coarse_tile_binner_unit;
  localparam int CycleLimit = 3_000_000;

  logic        clk, rst, start, busy;
  ctb_pkg::req_t req;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        result_strobe;
  ctb_pkg::result_t result;
  int          idle_mode;

  binner_scoreboard sb = new();

  coarse_tile_binner_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_strobe(result_strobe), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check(result);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // called at a falling edge; leaves start high so back-to-back requests need no toggle
  task automatic push(ctb_pkg::req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note(r);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (idle_mode == 1 && $urandom_range(99) < 80) n = $urandom_range(1, 8);
    if (idle_mode == 3 && $urandom_range(99) < 17) n = $urandom_range(1, 3);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ctb_pkg::req_t make_req(logic [1:0] k);
    ctb_pkg::req_t r;
    r = ctb_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
    r.kind = k;
    return r;
  endfunction

  function automatic ctb_pkg::req_t box_req(int x0, int y0, int x1, int y1, logic [15:0] id);
    ctb_pkg::req_t r;
    r = make_req(ctb_pkg::KIND_ADD);
    r.min_x = x0[15:0];
    r.min_y = y0[15:0];
    r.max_x = x1[15:0];
    r.max_y = y1[15:0];
    r.quad_id = id;
    return r;
  endfunction

  function automatic ctb_pkg::req_t read_req(int slab, int slot);
    ctb_pkg::req_t r;
    r = make_req(ctb_pkg::KIND_READ);
    r.slab_index = slab[12:0];
    r.slot_index = slot[3:0];
    return r;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic ctb_pkg::req_t random_req();
    ctb_pkg::req_t r;
    int p, w, h, x0, y0, a;
    p = $urandom_range(99);
    if (p < 55) begin
      r = make_req(ctb_pkg::KIND_ADD);
      if ($urandom_range(9) != 0) begin
        w = sb.side(sb.grid_x) * ctb_pkg::TileUnits;
        h = sb.side(sb.grid_y) * ctb_pkg::TileUnits;
        x0 = int'($urandom_range(0, w + 1024)) - 1024;
        y0 = int'($urandom_range(0, h + 1024)) - 1024;
        r.min_x = 16'(clip16(x0));
        r.min_y = 16'(clip16(y0));
        r.max_x = 16'(clip16(x0 + int'($urandom_range(0, 1700)) - 150));
        r.max_y = 16'(clip16(y0 + int'($urandom_range(0, 1700)) - 150));
      end
    end else if (p < 78 || sb.filled_list.size() == 0) begin
      r = make_req(ctb_pkg::KIND_REPORT);
    end else if (p < 98) begin
      a = sb.filled_list[$urandom_range(0, sb.filled_list.size() - 1)];
      r = read_req(a / ctb_pkg::QuadsPerSlab, a % ctb_pkg::QuadsPerSlab);
    end else begin
      r = make_req(ctb_pkg::KIND_CLEAR);
    end
    return r;
  endfunction

  initial begin
    logic [6:0] grid_xs[5] = '{7'd1, 7'd127, 7'd7, 7'd64, 7'd2};
    logic [6:0] grid_ys[5] = '{7'd1, 7'd0, 7'd5, 7'd64, 7'd9};
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_mode = 0;
    sb.wipe();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full-screen quads fill every tile's own slab, then exhaust the allocator
    for (int i = 0; i < 17; i++)
      push(box_req(-32768, -32768, 32767, 32767, (i == 0) ? 16'hFFFF : 16'(i * 4099)));
    push(read_req(8191, 0));
    push(read_req(4096, 15));
    push(read_req(1, 0));
    push(make_req(ctb_pkg::KIND_REPORT));
    push(make_req(ctb_pkg::KIND_REPORT));
    push(box_req(2000, 2000, 1000, 1000, 16'h1234));
    push(box_req(-32768, -32768, -1, -1, 16'h4321));
    push(make_req(ctb_pkg::KIND_CLEAR));
    push(make_req(ctb_pkg::KIND_REPORT));
    // sender holds off until everything is back
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ctb_pkg::REG_TILES_X, grid_xs[ph]);
      write_reg(ctb_pkg::REG_TILES_Y, grid_ys[ph]);
      idle_mode = ph % 4;
      for (int i = 0; i < 220; i++) begin
        push(random_req());
        sender_gap();
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: coarse_tile_binner_unit.f
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_front.sv
rtl/ctb_back.sv
rtl/coarse_tile_binner_unit.sv
test/tb_coarse_tile_binner_unit.sv
